FILE: hw/rtl/yuyv_to_rgb24_converter_macros.svh
// Assertion macros for the YUYV to RGB24 converter.
// Included by the top-level converter, which carries the concurrent checks; no other dependencies.
`ifndef YUYV_TO_RGB24_CONVERTER_MACROS_SVH
`define YUYV_TO_RGB24_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// Check a property while out of reset.
`define Y2R_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("y2r check failed");
// Check a property at every edge, reset included.
`define Y2R_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("y2r check failed");
`else
`define Y2R_ASSERT(label, clk, rst_n, prop)
`define Y2R_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

FILE: hw/rtl/y2r_pkg.sv
// Shared types and BT.601 constants for the YUYV to RGB24 converter.
// No dependencies.
package y2r_pkg;

  // Offsets removed before the multiply (9-bit signed domain).
  localparam logic signed [8:0]  LUMA_OFFSET   = 9'sd16;
  localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;

  // Fixed-point coefficients, scaled by 256.
  localparam logic signed [10:0] COEF_Y  = 11'sd298;
  localparam logic signed [10:0] COEF_RV = 11'sd409;
  localparam logic signed [10:0] COEF_GU = 11'sd100;
  localparam logic signed [10:0] COEF_GV = 11'sd208;
  localparam logic signed [10:0] COEF_BU = 11'sd516;
  localparam logic signed [19:0] ROUND_ADD = 20'sd128;

  typedef logic [7:0]         byte_t;
  typedef logic signed [8:0]  diff_t;
  typedef logic signed [19:0] wide_t;

  // Stage 1 -> 2: offset-removed components.
  typedef struct packed {
    diff_t c0;
    diff_t c1;
    diff_t d;
    diff_t e;
    logic  last;
  } diff_bus_t;

  // Stage 2 -> 3: weighted terms, luma terms carry the rounding constant.
  typedef struct packed {
    wide_t y0;
    wide_t y1;
    wide_t rv;
    wide_t gu;
    wide_t gv;
    wide_t bu;
    logic  last;
  } prod_bus_t;

  // Stage 3 -> 4: unclamped channel sums.
  typedef struct packed {
    wide_t r0;
    wide_t g0;
    wide_t b0;
    wide_t r1;
    wide_t g1;
    wide_t b1;
    logic  last;
  } sum_bus_t;

endpackage

FILE: hw/rtl/y2r_if.sv
// Stream interfaces for the YUYV to RGB24 converter: macropixel in, pixel pair out.
// Depends on y2r_pkg.
interface y2r_in_if;
  import y2r_pkg::*;
  logic  valid;
  logic  ready;
  byte_t luma0;
  byte_t chroma_blue;
  byte_t luma1;
  byte_t chroma_red;
  logic  last_in;

  modport source(output valid, luma0, chroma_blue, luma1, chroma_red, last_in, input ready);
  modport sink(input valid, luma0, chroma_blue, luma1, chroma_red, last_in, output ready);
endinterface

interface y2r_out_if;
  import y2r_pkg::*;
  logic  valid;
  logic  ready;
  byte_t red0;
  byte_t green0;
  byte_t blue0;
  byte_t red1;
  byte_t green1;
  byte_t blue1;
  logic  last_out;

  modport source(output valid, red0, green0, blue0, red1, green1, blue1, last_out,
                 input ready);
  modport sink(input valid, red0, green0, blue0, red1, green1, blue1, last_out,
               output ready);
endinterface

FILE: hw/rtl/y2r_offset.sv
// Stage 1: remove luma and chroma offsets from the incoming macropixel.
// Depends on y2r_pkg and y2r_in_if.
module y2r_offset (
  input  logic                clk,
  input  logic                rst_n,
  y2r_in_if.sink              in_chan,
  output logic                valid_o,
  input  logic                ready_i,
  output y2r_pkg::diff_bus_t  data_o
);
  import y2r_pkg::*;

  logic      valid_r;
  diff_bus_t data_r;
  diff_bus_t data_nxt;

  assign in_chan.ready = !valid_r || ready_i;

  always_comb begin
    data_nxt.c0   = $signed({1'b0, in_chan.luma0}) - LUMA_OFFSET;
    data_nxt.c1   = $signed({1'b0, in_chan.luma1}) - LUMA_OFFSET;
    data_nxt.d    = $signed({1'b0, in_chan.chroma_blue}) - CHROMA_OFFSET;
    data_nxt.e    = $signed({1'b0, in_chan.chroma_red}) - CHROMA_OFFSET;
    data_nxt.last = in_chan.last_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule

FILE: hw/rtl/y2r_mult.sv
// Stage 2: constant-coefficient products; luma terms pick up the rounding constant.
// Depends on y2r_pkg.
module y2r_mult (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  y2r_pkg::diff_bus_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output y2r_pkg::prod_bus_t  data_o
);
  import y2r_pkg::*;

  logic      valid_r;
  prod_bus_t data_r;
  prod_bus_t data_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    data_nxt.y0   = wide_t'(data_i.c0) * wide_t'(COEF_Y) + ROUND_ADD;
    data_nxt.y1   = wide_t'(data_i.c1) * wide_t'(COEF_Y) + ROUND_ADD;
    data_nxt.rv   = wide_t'(data_i.e) * wide_t'(COEF_RV);
    data_nxt.gu   = wide_t'(data_i.d) * wide_t'(COEF_GU);
    data_nxt.gv   = wide_t'(data_i.e) * wide_t'(COEF_GV);
    data_nxt.bu   = wide_t'(data_i.d) * wide_t'(COEF_BU);
    data_nxt.last = data_i.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule

FILE: hw/rtl/y2r_sum.sv
// Stage 3: combine luma and chroma terms into unclamped R, G, B sums.
// Depends on y2r_pkg.
module y2r_sum (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  output logic                ready_o,
  input  y2r_pkg::prod_bus_t  data_i,
  output logic                valid_o,
  input  logic                ready_i,
  output y2r_pkg::sum_bus_t   data_o
);
  import y2r_pkg::*;

  logic     valid_r;
  sum_bus_t data_r;
  sum_bus_t data_nxt;

  assign ready_o = !valid_r || ready_i;

  always_comb begin
    data_nxt.r0   = data_i.y0 + data_i.rv;
    data_nxt.g0   = data_i.y0 - data_i.gu - data_i.gv;
    data_nxt.b0   = data_i.y0 + data_i.bu;
    data_nxt.r1   = data_i.y1 + data_i.rv;
    data_nxt.g1   = data_i.y1 - data_i.gu - data_i.gv;
    data_nxt.b1   = data_i.y1 + data_i.bu;
    data_nxt.last = data_i.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      data_r <= data_nxt;
    end
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;
endmodule

FILE: hw/rtl/y2r_clamp.sv
// Stage 4: shift out the fraction, saturate to 0..255 and hold the output item.
// Depends on y2r_pkg and y2r_out_if.
module y2r_clamp (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               valid_i,
  output logic               ready_o,
  input  y2r_pkg::sum_bus_t  data_i,
  y2r_out_if.source          out_chan
);
  import y2r_pkg::*;

  logic  valid_r;
  byte_t red0_r, green0_r, blue0_r, red1_r, green1_r, blue1_r;
  logic  last_r;

  // Negative sums go to zero, anything past 255 after the shift saturates.
  function automatic byte_t sat8(input wide_t s);
    byte_t q;
    if (s[19]) begin
      q = 8'd0;
    end else if (|s[18:16]) begin
      q = 8'd255;
    end else begin
      q = s[15:8];
    end
    return q;
  endfunction

  assign ready_o = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_i && ready_o) begin
      red0_r   <= sat8(data_i.r0);
      green0_r <= sat8(data_i.g0);
      blue0_r  <= sat8(data_i.b0);
      red1_r   <= sat8(data_i.r1);
      green1_r <= sat8(data_i.g1);
      blue1_r  <= sat8(data_i.b1);
      last_r   <= data_i.last;
    end
  end

  assign out_chan.valid    = valid_r;
  assign out_chan.red0     = red0_r;
  assign out_chan.green0   = green0_r;
  assign out_chan.blue0    = blue0_r;
  assign out_chan.red1     = red1_r;
  assign out_chan.green1   = green1_r;
  assign out_chan.blue1    = blue1_r;
  assign out_chan.last_out = last_r;
endmodule

FILE: hw/rtl/yuyv_to_rgb24_converter.sv
// YUYV 4:2:2 to RGB24 converter, BT.601 studio range.
// Depends on y2r_pkg, y2r_if and the y2r stage modules.
//
// in_chan takes one packed macropixel per item (Y0, U, Y1, V plus a last flag);
// out_chan gives one item per input: two RGB24 pixels sharing the chroma, with
// the last flag copied through. Items leave in the order they arrive.
// The datapath is a four-stage pipeline: offset removal, constant multiplies,
// channel sums, clamp into the output register.
// An accepted item passes through the offset, multiply, sum and clamp registers in
// that order; out_chan.valid rises once it sits in the clamp register.
// Throughput: one item per cycle while the receiver holds out_chan.ready high; the
// constant multiplies in stage 2 are the deepest logic between registers.
// Each stage has its own valid bit and takes a new item whenever it is empty
// or its successor moves, so bubbles close up under backpressure. When the
// receiver stalls, the output item holds and upstream stages keep filling;
// in_chan.ready drops only once all four stages hold items.
// Reset (synchronous, active low) clears all valid bits; no item is in flight
// afterwards and there is no other state.
`include "yuyv_to_rgb24_converter_macros.svh"

module yuyv_to_rgb24_converter (
  input  logic       clk,
  input  logic       rst_n,
  y2r_in_if.sink     in_chan,
  y2r_out_if.source  out_chan
);
  import y2r_pkg::*;

  logic      s1_valid, s1_ready;
  logic      s2_valid, s2_ready;
  logic      s3_valid, s3_ready;
  diff_bus_t s1_data;
  prod_bus_t s2_data;
  sum_bus_t  s3_data;

  y2r_offset u_offset (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .valid_o (s1_valid),
    .ready_i (s1_ready),
    .data_o  (s1_data)
  );

  y2r_mult u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  y2r_sum u_sum (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  y2r_clamp u_clamp (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_i  (s3_valid),
    .ready_o  (s3_ready),
    .data_i   (s3_data),
    .out_chan (out_chan)
  );

  // Nothing in flight right after reset.
  `Y2R_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_chan.valid)
  // An empty output stage lets every stage advance.
  `Y2R_ASSERT(a_empty_ready, clk, rst_n, !out_chan.valid |-> in_chan.ready)
  // A ready receiver never backs up the input.
  `Y2R_ASSERT(a_flow_ready, clk, rst_n, out_chan.ready |-> in_chan.ready)
  // With the receiver ready throughout, an accepted item comes out with its flag.
  `Y2R_ASSERT(a_latency, clk, rst_n,
    ($past(in_chan.valid && in_chan.ready, 4) && $past(out_chan.ready, 1) &&
     $past(out_chan.ready, 2) && $past(out_chan.ready, 3) && $past(rst_n, 1) &&
     $past(rst_n, 2) && $past(rst_n, 3))
    |-> (out_chan.valid && (out_chan.last_out == $past(in_chan.last_in, 4))))

endmodule

FILE: tb/yuyv_to_rgb24_converter_tb.sv
// Self-checking bench for yuyv_to_rgb24_converter: directed corners, then random macropixels,
// each result compared with a typed value or a BT.601 integer predictor, mostly under random idling on both sides.
// Depends on y2r_pkg, y2r_if and the converter RTL.
`timescale 1ns / 1ps

module yuyv_to_rgb24_converter_tb;
  import y2r_pkg::*;

  typedef struct packed {
    byte_t red0;
    byte_t green0;
    byte_t blue0;
    byte_t red1;
    byte_t green1;
    byte_t blue1;
    logic  last;
  } rgb_pair_t;

  typedef struct {
    byte_t     luma0;
    byte_t     cb;
    byte_t     luma1;
    byte_t     cr;
    logic      last;
    bit        typed;
    rgb_pair_t want;
  } pair_stim_t;

  localparam rgb_pair_t BLACK_PAIR = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0};
  localparam rgb_pair_t WHITE_PAIR = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0};
  localparam int        RANDOM_ITEMS = 1130;
  localparam int        CALM_TAIL    = 150;
  localparam int        MAX_REPORTS  = 10;

  logic clk;
  logic rst_n;

  y2r_in_if  in_chan();
  y2r_out_if out_chan();

  yuyv_to_rgb24_converter i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rgb_pair_t  pending_pairs[$];
  pair_stim_t directed_rows[$];
  int         fail_count;
  int         pairs_checked;
  int         items_sent;
  int         typed_sent;
  int         frame_ends;
  int         idle_odds;   // one burst in idle_odds chances; 0 turns idling off
  int         stall_left;

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("yuyv_to_rgb24_converter_tb failed");
    $finish;
  end

  function automatic byte_t clamp_channel(int sum);
    int q;
    if (sum < 0) return 8'h00;
    q = sum >>> 8;
    if (q > 255) return 8'hFF;
    return q[7:0];
  endfunction

  function automatic rgb_pair_t bt601_pair(byte_t luma0, byte_t cb, byte_t luma1, byte_t cr,
                                           logic last);
    int        d;
    int        e;
    int        yy0;
    int        yy1;
    rgb_pair_t px;
    d   = int'(cb) - int'(CHROMA_OFFSET);
    e   = int'(cr) - int'(CHROMA_OFFSET);
    yy0 = int'(COEF_Y) * (int'(luma0) - int'(LUMA_OFFSET)) + int'(ROUND_ADD);
    yy1 = int'(COEF_Y) * (int'(luma1) - int'(LUMA_OFFSET)) + int'(ROUND_ADD);
    px.red0   = clamp_channel(yy0 + int'(COEF_RV) * e);
    px.green0 = clamp_channel(yy0 - int'(COEF_GU) * d - int'(COEF_GV) * e);
    px.blue0  = clamp_channel(yy0 + int'(COEF_BU) * d);
    px.red1   = clamp_channel(yy1 + int'(COEF_RV) * e);
    px.green1 = clamp_channel(yy1 - int'(COEF_GU) * d - int'(COEF_GV) * e);
    px.blue1  = clamp_channel(yy1 + int'(COEF_BU) * d);
    px.last   = last;
    return px;
  endfunction

  // Bytes around the studio-range limits and the chroma midpoint.
  function automatic byte_t corner_byte();
    byte_t      corner_vals[13] = '{8'd0, 8'd1, 8'd15, 8'd16, 8'd17, 8'd127, 8'd128, 8'd129,
                                    8'd234, 8'd235, 8'd236, 8'd254, 8'd255};
    logic [3:0] pick;
    pick = 4'($urandom_range(0, 12));
    return corner_vals[pick];
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom_range(0, 255));
  endfunction

  function automatic void note_failure(string what, rgb_pair_t want, rgb_pair_t got);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%t %s: expected rgb0=%h %h %h rgb1=%h %h %h last=%b,",
               $realtime, what, want.red0, want.green0, want.blue0, want.red1, want.green1,
               want.blue1, want.last);
      $display("    got rgb0=%h %h %h rgb1=%h %h %h last=%b",
               got.red0, got.green0, got.blue0, got.red1, got.green1, got.blue1, got.last);
    end
  endfunction

  task automatic send_pair(pair_stim_t s);
    int gap;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      gap = $urandom_range(1, 9);
      repeat (gap) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
      end
    end
    @(negedge clk);
    in_chan.valid       = 1'b1;
    in_chan.luma0       = s.luma0;
    in_chan.chroma_blue = s.cb;
    in_chan.luma1       = s.luma1;
    in_chan.chroma_red  = s.cr;
    in_chan.last_in     = s.last;
    do @(posedge clk); while (!in_chan.ready);
    pending_pairs.push_back(s.typed ? s.want : bt601_pair(s.luma0, s.cb, s.luma1, s.cr, s.last));
    items_sent++;
    if (s.typed) typed_sent++;
    if (s.last) frame_ends++;
  endtask

  // Result side: random stall bursts, none started while idle_odds is zero.
  initial begin
    out_chan.ready = 1'b0;
    stall_left     = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_chan.ready = 1'b0;
        stall_left--;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        out_chan.ready = 1'b0;
        stall_left     = $urandom_range(1, 9) - 1;
      end else begin
        out_chan.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rgb_pair_t got;
    rgb_pair_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.red0, out_chan.green0, out_chan.blue0, out_chan.red1, out_chan.green1,
              out_chan.blue1, out_chan.last_out};
      if (pending_pairs.size() == 0) begin
        note_failure("result with nothing pending", got, got);
      end else begin
        want = pending_pairs.pop_front();
        pairs_checked++;
        if (got.red0 !== want.red0 || got.green0 !== want.green0 || got.blue0 !== want.blue0 ||
            got.red1 !== want.red1 || got.green1 !== want.green1 || got.blue1 !== want.blue1 ||
            got.last !== want.last)
          note_failure("pixel pair mismatch", want, got);
      end
    end
  end

  initial begin
    pair_stim_t s;
    int         mode;
    fail_count          = 0;
    pairs_checked       = 0;
    items_sent          = 0;
    typed_sent          = 0;
    frame_ends          = 0;
    idle_odds           = 4;
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.luma0       = 8'h00;
    in_chan.chroma_blue = 8'h00;
    in_chan.luma1       = 8'h00;
    in_chan.chroma_red  = 8'h00;
    in_chan.last_in     = 1'b0;

    // Black, white and the luma extremes with neutral chroma are typed in.
    directed_rows.push_back('{8'd16,  8'd128, 8'd16,  8'd128, 1'b0, 1'b1, BLACK_PAIR});
    directed_rows.push_back('{8'd235, 8'd128, 8'd235, 8'd128, 1'b0, 1'b1, WHITE_PAIR});
    directed_rows.push_back('{8'd0,   8'd128, 8'd0,   8'd128, 1'b0, 1'b1, BLACK_PAIR});
    directed_rows.push_back('{8'd255, 8'd128, 8'd255, 8'd128, 1'b0, 1'b1, WHITE_PAIR});
    directed_rows.push_back('{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd0,   8'd255, 8'd255, 8'd0,   1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd255, 8'd0,   8'd0,   8'd255, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd128, 8'd0,   8'd128, 8'd255, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd128, 8'd255, 8'd128, 8'd0,   1'b1, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd81,  8'd90,  8'd81,  8'd240, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd145, 8'd54,  8'd145, 8'd34,  1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd41,  8'd240, 8'd41,  8'd110, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd16,  8'd255, 8'd235, 8'd128, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd235, 8'd0,   8'd16,  8'd255, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd1,   8'd128, 8'd254, 8'd128, 1'b1, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'd128, 8'd128, 8'd128, 8'd128, 1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'h55,  8'hAA,  8'hAA,  8'h55,  1'b0, 1'b0, BLACK_PAIR});
    directed_rows.push_back('{8'hAA,  8'h55,  8'h55,  8'hAA,  1'b1, 1'b0, BLACK_PAIR});

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) send_pair(directed_rows[i]);

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      // Change the idling rate every hundred items; hold it off for the tail.
      if (k >= RANDOM_ITEMS - CALM_TAIL) idle_odds = 0;
      else if (k % 100 == 0) idle_odds = $urandom_range(0, 2) * 3;
      mode = $urandom_range(0, 9);
      s.typed = 1'b0;
      s.want  = BLACK_PAIR;
      s.last  = ($urandom_range(0, 7) == 0);
      if (mode <= 5) begin
        s.luma0 = rand_byte();
        s.cb    = rand_byte();
        s.luma1 = rand_byte();
        s.cr    = rand_byte();
      end else if (mode <= 7) begin
        s.luma0 = corner_byte();
        s.cb    = corner_byte();
        s.luma1 = corner_byte();
        s.cr    = corner_byte();
      end else begin
        // Saturated chroma drives the channel sums past both clamp limits.
        s.luma0 = rand_byte();
        s.luma1 = rand_byte();
        s.cb    = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        s.cr    = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      send_pair(s);
    end

    @(negedge clk);
    in_chan.valid = 1'b0;
    wait (pending_pairs.size() == 0);
    repeat (12) @(posedge clk);

    $display("Sent %0d macropixel items (%0d with typed results, %0d frame ends).",
             items_sent, typed_sent, frame_ends);
    $display("Checked %0d pixel pairs, %0d failures.", pairs_checked, fail_count);
    if (fail_count == 0 && pending_pairs.size() == 0) begin
      $display("yuyv_to_rgb24_converter_tb passed");
    end else begin
      $display("yuyv_to_rgb24_converter_tb failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/y2r_pkg.sv
hw/rtl/y2r_if.sv
hw/rtl/y2r_offset.sv
hw/rtl/y2r_mult.sv
hw/rtl/y2r_sum.sv
hw/rtl/y2r_clamp.sv
hw/rtl/yuyv_to_rgb24_converter.sv
tb/yuyv_to_rgb24_converter_tb.sv
